// ===== design/byte_ring_fifo_with_line_peek_unit_assert.svh =====
// Assertion macros used by the checker module.
`ifndef BYTE_RING_FIFO_WITH_LINE_PEEK_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_LINE_PEEK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/brf_pkg.sv =====
`timescale 1ns / 1ps

package brf_pkg;

   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 12;
   localparam int LINE_W = 6;
   localparam int CSR_IDX_W = 2;

   // line peek buffer limit; at most MaxLine - 1 bytes are returned
   localparam int MaxLine = 64;
   localparam int LIM_W   = $clog2(MaxLine + 1);

   localparam logic [BYTE_W-1:0] CR_BYTE          = 8'd13;
   localparam logic [BYTE_W-1:0] DELIM_RESET      = 8'd10;
   localparam logic [CNT_W-1:0]  MAX_INSERT_RESET = 12'd1500;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INSERT = 2'd1;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LINE   = 3'd5;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_HEADER,
      OP_BYTE,
      OP_PEEK,
      OP_POP,
      OP_LINE,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEEK,
      ST_SCAN,
      ST_REWIND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data;
      logic [CNT_W-1:0]    count;
      logic [LINE_W-1:0]   max_copy;
   } cmd_type;

   typedef struct packed {
      logic                ok;
      logic [BYTE_W-1:0]   read_byte;
      logic [CNT_W-1:0]    used_bytes;
      logic [CNT_W-1:0]    free_bytes;
      logic [LINE_W-1:0]   line_count;
      logic                found;
      logic                last;
   } rsp_type;

endpackage

// ===== design/brf_chan_if.sv =====
`timescale 1ns / 1ps

interface brf_req_if import brf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_byte;
   logic [CNT_W-1:0]  count;

   modport source (output valid, kind, data_byte, count, input ready);
   modport sink (input valid, kind, data_byte, count, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*;;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [BYTE_W-1:0] read_byte;
   logic [CNT_W-1:0]  used_bytes;
   logic [CNT_W-1:0]  free_bytes;
   logic [LINE_W-1:0] line_count;
   logic              found;
   logic              last;

   modport source (output valid, ok, read_byte, used_bytes, free_bytes, line_count, found,
                   last, input ready);
   modport sink (input valid, ok, read_byte, used_bytes, free_bytes, line_count, found,
                 last, output ready);
endinterface

interface brf_csr_if import brf_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CNT_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/brf_ram.sv =====
`timescale 1ns / 1ps

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/brf_front.sv =====
`timescale 1ns / 1ps

module brf_front import brf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   brf_req_if.sink req,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_ready
);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   cmd_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   cmd_type            cmd_in;
   logic [LIM_W-1:0]   limit;
   logic               push, pop;

   // classify the beat and work out the line peek copy bound
   always_comb begin
      cmd_in       = '0;
      cmd_in.data  = req.data_byte;
      cmd_in.count = req.count;
      unique case (req.kind)
         KIND_CLEAR:  cmd_in.op = OP_CLEAR;
         KIND_HEADER: cmd_in.op = OP_HEADER;
         KIND_BYTE:   cmd_in.op = OP_BYTE;
         KIND_PEEK:   cmd_in.op = OP_PEEK;
         KIND_POP:    cmd_in.op = OP_POP;
         KIND_LINE:   cmd_in.op = OP_LINE;
         default:     cmd_in.op = OP_NONE;
      endcase
      limit = (req.count < CNT_W'(MaxLine)) ? req.count[LIM_W-1:0] : LIM_W'(MaxLine);
      cmd_in.max_copy = (limit == '0) ? '0 : LINE_W'(limit - 1'b1);
   end

   assign req.ready = (fill_ff != QCNT_W'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== design/brf_back.sv =====
`timescale 1ns / 1ps

module brf_back import brf_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      cmd_valid,
   output logic      cmd_ready,
   brf_csr_if.sink   csr,
   brf_rsp_if.source rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int WW = (AW > CNT_W ? AW : CNT_W) + 1;
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] add_idx(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] to_cnt(input logic [AW-1:0] v);
      logic [WW-1:0] wide;
      wide = WW'(v);
      return wide[CNT_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [AW-1:0]      stage_ff, stage_in;
   logic [CNT_W-1:0]   pending_ff, pending_in;
   logic [CNT_W-1:0]   ins_len_ff, ins_len_in;
   logic [AW-1:0]      used_ff, used_in;
   logic [BYTE_W-1:0]  delim_ff;
   logic [CNT_W-1:0]   max_ins_ff;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [LINE_W-1:0]  nbytes_ff, nbytes_in;
   logic [LINE_W-1:0]  idx_ff, idx_in;
   logic [LINE_W-1:0]  max_copy_ff, max_copy_in;
   logic               found_ff, found_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               out_load;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_ra;
   logic [BYTE_W-1:0]  rd_data;

   logic               out_free, take;
   logic [WW-1:0]      used_w, cnt_w, free_w, commit_sum;
   logic [AW-1:0]      cnt_idx;
   logic               peek_hit, pop_ok, hdr_ok;
   logic               is_delim, is_cr, scan_more, scan_take, emit_last;

   brf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (stage_ff),
      .wr_data (cmd.data),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;

   assign used_w     = WW'(used_ff);
   assign cnt_w      = WW'(cmd.count);
   assign free_w     = WW'(LAST_IDX - used_ff);
   assign cnt_idx    = cnt_w[AW-1:0];
   assign commit_sum = used_w + WW'(ins_len_ff);
   assign peek_hit   = cnt_w < used_w;
   assign pop_ok     = cnt_w <= used_w;
   assign hdr_ok     = (cmd.count <= max_ins_ff) && (cnt_w <= free_w);

   // scan: first pass counts the line, second pass replays it
   assign is_delim  = (rd_data == delim_ff);
   assign is_cr     = (rd_data == CR_BYTE);
   assign scan_more = (WW'(nbytes_ff) < used_w) && (nbytes_ff < max_copy_ff);
   assign scan_take = scan_more && (!found_ff || is_delim || is_cr);
   assign emit_last = (idx_ff == LINE_W'(nbytes_ff - 1'b1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && cmd.op == OP_PEEK && peek_hit) begin
               state_in = ST_PEEK;
            end else if (take && cmd.op == OP_LINE) begin
               state_in = ST_SCAN;
            end
         end
         ST_PEEK: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (!scan_take) state_in = ST_REWIND;
         end
         ST_REWIND: begin
            if (nbytes_ff != '0) begin
               state_in = ST_EMIT;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      stage_in    = stage_ff;
      pending_in  = pending_ff;
      ins_len_in  = ins_len_ff;
      used_in     = used_ff;
      pos_in      = pos_ff;
      nbytes_in   = nbytes_ff;
      idx_in      = idx_ff;
      max_copy_in = max_copy_ff;
      found_in    = found_ff;
      out_load    = 1'b0;
      out_in      = '0;
      out_in.last = 1'b1;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_ra      = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               out_load = 1'b1;
               unique case (cmd.op)
                  OP_CLEAR: begin
                     head_in    = '0;
                     tail_in    = '0;
                     stage_in   = '0;
                     pending_in = '0;
                     used_in    = '0;
                     out_in.ok  = 1'b1;
                  end
                  OP_HEADER: begin
                     // any header drops an unfinished insert
                     pending_in = '0;
                     if (hdr_ok) begin
                        out_in.ok  = 1'b1;
                        stage_in   = tail_ff;
                        pending_in = cmd.count;
                        ins_len_in = cmd.count;
                     end
                  end
                  OP_BYTE: begin
                     if (pending_ff != '0) begin
                        ram_we     = 1'b1;
                        stage_in   = inc_idx(stage_ff);
                        pending_in = pending_ff - 1'b1;
                        out_in.ok  = 1'b1;
                        if (pending_ff == CNT_W'(1)) begin
                           tail_in = inc_idx(stage_ff);
                           used_in = commit_sum[AW-1:0];
                        end
                     end
                  end
                  OP_PEEK: begin
                     if (peek_hit) begin
                        ram_re   = 1'b1;
                        ram_ra   = add_idx(head_ff, cnt_idx);
                        out_load = 1'b0;
                     end
                  end
                  OP_POP: begin
                     if (pop_ok) begin
                        head_in   = add_idx(head_ff, cnt_idx);
                        used_in   = used_ff - cnt_idx;
                        out_in.ok = 1'b1;
                     end
                  end
                  OP_LINE: begin
                     ram_re      = 1'b1;
                     ram_ra      = head_ff;
                     pos_in      = head_ff;
                     nbytes_in   = '0;
                     found_in    = 1'b0;
                     max_copy_in = cmd.max_copy;
                     out_load    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PEEK: begin
            out_load         = out_free;
            out_in.ok        = 1'b1;
            out_in.read_byte = rd_data;
         end
         ST_SCAN: begin
            if (scan_take) begin
               nbytes_in = nbytes_ff + 1'b1;
               found_in  = found_ff | is_delim;
               pos_in    = inc_idx(pos_ff);
               ram_re    = 1'b1;
               ram_ra    = inc_idx(pos_ff);
            end
         end
         ST_REWIND: begin
            if (nbytes_ff == '0) begin
               out_load     = out_free;
               out_in.ok    = found_ff;
               out_in.found = found_ff;
            end else begin
               ram_re = 1'b1;
               ram_ra = head_ff;
               pos_in = head_ff;
               idx_in = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_in.ok         = found_ff;
               out_in.read_byte  = rd_data;
               out_in.last       = emit_last;
               out_in.line_count = emit_last ? nbytes_ff : '0;
               out_in.found      = emit_last && found_ff;
               if (!emit_last) begin
                  idx_in = idx_ff + 1'b1;
                  pos_in = inc_idx(pos_ff);
                  ram_re = 1'b1;
                  ram_ra = inc_idx(pos_ff);
               end
            end
         end
         default: ;
      endcase

      out_in.used_bytes = to_cnt(used_in);
      out_in.free_bytes = to_cnt(LAST_IDX - used_in);
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         stage_ff     <= '0;
         pending_ff   <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
         delim_ff     <= DELIM_RESET;
         max_ins_ff   <= MAX_INSERT_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         stage_ff     <= stage_in;
         pending_ff   <= pending_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
         if (csr.valid && csr.index == CSR_DELIMITER) begin
            delim_ff <= csr.data[BYTE_W-1:0];
         end
         if (csr.valid && csr.index == CSR_MAX_INSERT) begin
            max_ins_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ins_len_ff  <= ins_len_in;
      pos_ff      <= pos_in;
      nbytes_ff   <= nbytes_in;
      idx_ff      <= idx_in;
      max_copy_ff <= max_copy_in;
      found_ff    <= found_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = out_valid_ff;
   assign rsp.ok         = out_ff.ok;
   assign rsp.read_byte  = out_ff.read_byte;
   assign rsp.used_bytes = out_ff.used_bytes;
   assign rsp.free_bytes = out_ff.free_bytes;
   assign rsp.line_count = out_ff.line_count;
   assign rsp.found      = out_ff.found;
   assign rsp.last       = out_ff.last;

endmodule

// ===== design/byte_ring_fifo_with_line_peek_unit.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Beat contents
// req_chan   in   kind, data_byte, count
// rsp_chan   out  ok, read_byte, used_bytes, free_bytes, line_count, found, last
// csr_chan   in   index (0 delimiter, 1 max_insert), data
//
// Clear, insert header, insert byte, pop, out-of-range peek and unused kinds finish in
// ST_IDLE, back to back while rsp_chan is ready. Peek in range adds a state (ST_PEEK)
// for the registered read of the byte store. A line peek walks the store's single read
// port once to find the line end and once more to return the bytes.
// Reset is synchronous and empties the ring at once; the store itself is not cleared.
// A two-beat command queue lets req_chan run ahead while a response waits on rsp_chan.
module byte_ring_fifo_with_line_peek_unit import brf_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_chan,
   brf_rsp_if.source rsp_chan,
   brf_csr_if.sink   csr_chan
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   brf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   brf_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .csr       (csr_chan),
      .rsp       (rsp_chan)
   );

endmodule

// ===== design/brf_checker.sv =====
`timescale 1ns / 1ps

`include "byte_ring_fifo_with_line_peek_unit_assert.svh"

module brf_checker import brf_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_ok,
   input logic [BYTE_W-1:0] rsp_read_byte,
   input logic [CNT_W-1:0]  rsp_used_bytes,
   input logic [CNT_W-1:0]  rsp_free_bytes,
   input logic [LINE_W-1:0] rsp_line_count,
   input logic              rsp_found,
   input logic              rsp_last
);

   localparam logic [CNT_W-1:0] FULL_SUM = CNT_W'(DEPTH - 1);

   `BRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_used_bytes) && $stable(rsp_last), "rsp beat changed while stalled")

   `BRF_ASSERT_NOW(a_used_free_sum, clock, reset, rsp_valid, CNT_W'(rsp_used_bytes + rsp_free_bytes) == FULL_SUM, "used plus free does not match ring size")

   `BRF_ASSERT_NOW(a_mid_line_clean, clock, reset, rsp_valid && !rsp_last, rsp_line_count == '0 && !rsp_found, "line summary on a non-final beat")

   `BRF_ASSERT_NOW(a_line_summary, clock, reset, rsp_valid && rsp_line_count != '0, rsp_last && rsp_ok == rsp_found, "line count without matching final beat")

   `BRF_ASSERT_NEXT(a_line_counts_stable, clock, reset, rsp_valid && rsp_ready && !rsp_last, $stable(rsp_used_bytes) && $stable(rsp_free_bytes), "fill level moved inside a line peek")

endmodule

bind byte_ring_fifo_with_line_peek_unit brf_checker #(.DEPTH(DEPTH)) u_brf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ok         (rsp_chan.ok),
   .rsp_read_byte  (rsp_chan.read_byte),
   .rsp_used_bytes (rsp_chan.used_bytes),
   .rsp_free_bytes (rsp_chan.free_bytes),
   .rsp_line_count (rsp_chan.line_count),
   .rsp_found      (rsp_chan.found),
   .rsp_last       (rsp_chan.last)
);

// ===== dv/byte_ring_fifo_with_line_peek_unit_test.sv =====
`timescale 1ns / 1ps

module byte_ring_fifo_with_line_peek_unit_test import brf_pkg::*; ;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 2 * MaxLine + 16;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_REPORTS   = 40;

   class line_fifo_scoreboard;
      localparam int RING_DEPTH = 4096;
      logic [BYTE_W-1:0] ring [RING_DEPTH];
      int head, tail, staging, pending;
      logic [BYTE_W-1:0] delim;
      int max_ins;
      rsp_type due_responses [$];
      int errors, checked, line_peeks, lines_found;
      bit full_seen, wrap_seen;

      function new();
         head = 0;
         tail = 0;
         staging = 0;
         pending = 0;
         delim = DELIM_RESET;
         max_ins = MAX_INSERT_RESET;
      endfunction

      function int used_count();
         return (tail + RING_DEPTH - head) % RING_DEPTH;
      endfunction

      function bit header_fits(int len);
         return len <= max_ins && len <= RING_DEPTH - used_count() - 1;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
         if (idx == CSR_DELIMITER)
            delim = value[BYTE_W-1:0];
         else if (idx == CSR_MAX_INSERT)
            max_ins = value;
      endfunction

      function void queue_response(bit ok, logic [BYTE_W-1:0] rb, int lc, bit fnd, bit fin);
         rsp_type r;
         int used;
         used = used_count();
         r.ok = ok;
         r.read_byte = rb;
         r.used_bytes = CNT_W'(used);
         r.free_bytes = CNT_W'(RING_DEPTH - used - 1);
         r.line_count = LINE_W'(lc);
         r.found = fnd;
         r.last = fin;
         if (used == RING_DEPTH - 1) full_seen = 1;
         due_responses.push_back(r);
      endfunction

      function void apply_request(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                  logic [CNT_W-1:0] count);
         logic [BYTE_W-1:0] line_buf [MaxLine];
         logic [BYTE_W-1:0] rb;
         int lim, max_copy, n, pos, k, used;
         bit ok, fnd;
         ok = 0;
         rb = '0;
         case (kind)
            KIND_CLEAR: begin
               head = 0;
               tail = 0;
               staging = 0;
               pending = 0;
               ok = 1;
            end
            KIND_HEADER: begin
               // any header drops a pending insert
               pending = 0;
               if (header_fits(count)) begin
                  ok = 1;
                  staging = tail;
                  pending = count;
               end
            end
            KIND_BYTE: begin
               if (pending > 0) begin
                  ring[staging] = data;
                  staging = (staging + 1) % RING_DEPTH;
                  if (staging == 0) wrap_seen = 1;
                  pending--;
                  if (pending == 0) tail = staging;
                  ok = 1;
               end
            end
            KIND_PEEK: begin
               if (count < used_count()) begin
                  ok = 1;
                  rb = ring[(head + count) % RING_DEPTH];
               end
            end
            KIND_POP: begin
               if (count <= used_count()) begin
                  ok = 1;
                  head = (head + count) % RING_DEPTH;
               end
            end
            KIND_LINE: begin
               line_peeks++;
               lim = (count < MaxLine) ? count : MaxLine;
               max_copy = (lim > 0) ? lim - 1 : 0;
               used = used_count();
               pos = head;
               n = 0;
               fnd = 0;
               while (n < used && n < max_copy && ring[pos] != delim) begin
                  line_buf[n] = ring[pos];
                  n++;
                  pos = (pos + 1) % RING_DEPTH;
               end
               // take the whole run of line-end bytes
               while (n < used && n < max_copy && (ring[pos] == delim || ring[pos] == CR_BYTE))
               begin
                  line_buf[n] = ring[pos];
                  n++;
                  pos = (pos + 1) % RING_DEPTH;
                  fnd = 1;
               end
               if (fnd) lines_found++;
               if (n == 0)
                  queue_response(fnd, '0, 0, fnd, 1);
               else
                  for (k = 0; k < n; k++)
                     queue_response(fnd, line_buf[k], (k == n - 1) ? n : 0,
                                    (k == n - 1) && fnd, k == n - 1);
               return;
            end
            default: ;
         endcase
         queue_response(ok, rb, 0, 0, 1);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response beat with none outstanding, expected none, actual %p",
                        $time, got);
            return;
         end
         want = due_responses.pop_front();
         checked++;
         compare_field("ok", want.ok, got.ok);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("used_bytes", want.used_bytes, got.used_bytes);
         compare_field("free_bytes", want.free_bytes, got.free_bytes);
         compare_field("line_count", want.line_count, got.line_count);
         compare_field("found", want.found, got.found);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit calm;
   bit pressure_req;
   int requests_sent;
   int useful_items;
   int settings_used;
   line_fifo_scoreboard sb;

   brf_req_if req_if ();
   brf_rsp_if rsp_if ();
   brf_csr_if csr_if ();

   byte_ring_fifo_with_line_peek_unit #(.DEPTH(4096)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         got.ok = rsp_if.ok;
         got.read_byte = rsp_if.read_byte;
         got.used_bytes = rsp_if.used_bytes;
         got.free_bytes = rsp_if.free_bytes;
         got.line_count = rsp_if.line_count;
         got.found = rsp_if.found;
         got.last = rsp_if.last;
         sb.check_response(got);
      end
   end

   // response side pacing: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      int run_left;
      hold_left = 0;
      run_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_if.ready = 1'b0;
         end else if (calm || run_left > 0) begin
            rsp_if.ready = 1'b1;
            if (run_left > 0) run_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            hold_left = $urandom_range(0, 17);
            rsp_if.ready = 1'b0;
         end else begin
            run_left = $urandom_range(0, 40);
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                               input logic [CNT_W-1:0] count);
      bit ignored;
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.kind = kind;
      req_if.data_byte = data;
      req_if.count = count;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      ignored = (kind == KIND_BYTE && sb.pending == 0) || kind > KIND_LINE;
      sb.apply_request(kind, data, count);
      requests_sent++;
      if (!ignored) useful_items++;
   endtask

   task automatic maybe_pause();
      int gap;
      if (calm || $urandom_range(0, 5) != 0) return;
      gap = $urandom_range(1, 18);
      @(negedge clock) req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = value;
      forever begin
         @(posedge clock);
         if (csr_if.ready) break;
      end
      sb.set_register(idx, value);
      @(negedge clock) csr_if.valid = 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_if.valid = 1'b0;
      while (sb.due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic retune(input logic [BYTE_W-1:0] delim, input logic [CNT_W-1:0] max_len);
      wait_idle();
      write_reg(CSR_DELIMITER, CNT_W'(delim));
      write_reg(CSR_MAX_INSERT, max_len);
      settings_used++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte(bit bulk);
      int roll;
      roll = $urandom_range(0, bulk ? 47 : 7);
      if (roll < 2) return sb.delim;
      if (roll == 2) return CR_BYTE;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // header of len, then sent_bytes bytes if the header fits; bulk makes line-end bytes rarer
   task automatic send_insert(input int len, input int sent_bytes, input bit bulk);
      bit fits;
      int i;
      fits = sb.header_fits(len);
      send_request(KIND_HEADER, BYTE_W'($urandom_range(0, 255)), CNT_W'(len));
      if (fits)
         for (i = 0; i < sent_bytes; i++) begin
            maybe_pause();
            send_request(KIND_BYTE, pick_byte(bulk), CNT_W'($urandom_range(0, 4095)));
         end
   endtask

   task automatic random_traffic(input int n_items);
      int goal, used, pick, len, roll, cnt;
      goal = useful_items + n_items;
      while (useful_items < goal) begin
         used = sb.used_count();
         pick = $urandom_range(0, 99);
         roll = $urandom_range(0, 7);
         maybe_pause();
         if (pick < 42) begin
            len = (roll == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            send_insert(len, len, 0);
         end else if (pick < 47) begin
            // broken insert: fewer bytes than announced
            len = $urandom_range(2, 10);
            send_insert(len, $urandom_range(0, len - 1), 0);
         end else if (pick < 59) begin
            if (used > 0 && roll < 5) cnt = $urandom_range(0, used - 1);
            else if (roll < 7) cnt = used;
            else cnt = $urandom_range(0, 4095);
            send_request(KIND_PEEK, BYTE_W'($urandom_range(0, 255)), CNT_W'(cnt));
         end else if (pick < 69) begin
            if (used > 0 && roll < 4) cnt = $urandom_range(0, (used < 8) ? used : 8);
            else if (roll == 4) cnt = used;
            else if (roll == 5) cnt = used + 1;
            else cnt = $urandom_range(0, 4095);
            send_request(KIND_POP, BYTE_W'($urandom_range(0, 255)), CNT_W'(cnt));
         end else if (pick < 85) begin
            if (roll == 0) cnt = $urandom_range(0, 4095);
            else if (roll == 1) cnt = $urandom_range(0, 2);
            else cnt = $urandom_range(3, 70);
            send_request(KIND_LINE, BYTE_W'($urandom_range(0, 255)), CNT_W'(cnt));
         end else if (pick < 88) begin
            send_request(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)),
                         CNT_W'($urandom_range(0, 4095)));
         end else if (pick < 92) begin
            send_request(KIND_BYTE, pick_byte(0), CNT_W'($urandom_range(0, 4095)));
         end else if (pick < 95) begin
            send_request(roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO,
                         BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 4095)));
         end else begin
            send_request(KIND_HEADER, BYTE_W'($urandom_range(0, 255)),
                         CNT_W'($urandom_range(0, 4095)));
         end
      end
   endtask

   task automatic directed_checks();
      send_request(KIND_BYTE, 8'h5A, 12'd0);
      send_request(KIND_PEEK, 8'h00, 12'd0);
      send_request(KIND_POP, 8'h00, 12'd0);
      send_request(KIND_POP, 8'h00, 12'd1);
      send_request(KIND_LINE, 8'h00, 12'd5);
      send_request(KIND_SPARE_HI, 8'hFF, 12'hFFF);
      send_request(KIND_SPARE_LO, 8'h00, 12'h000);
      send_request(KIND_HEADER, 8'h00, 12'd0);
      send_request(KIND_HEADER, 8'h00, MAX_INSERT_RESET + 12'd1);
      send_request(KIND_HEADER, 8'h00, 12'd5);
      send_request(KIND_BYTE, 8'h41, 12'd0);
      send_request(KIND_BYTE, 8'hFF, 12'd0);
      send_request(KIND_BYTE, CR_BYTE, 12'd0);
      send_request(KIND_BYTE, DELIM_RESET, 12'd0);
      send_request(KIND_BYTE, 8'h00, 12'd0);
      send_request(KIND_PEEK, 8'h00, 12'd4);
      send_request(KIND_PEEK, 8'h00, 12'd5);
      send_request(KIND_LINE, 8'h00, 12'd64);
      send_request(KIND_LINE, 8'h00, 12'd0);
      send_request(KIND_LINE, 8'h00, 12'd1);
      send_request(KIND_LINE, 8'h00, 12'd2);
      send_request(KIND_LINE, 8'h00, 12'hFFF);
      send_request(KIND_HEADER, 8'h00, 12'd3);
      send_request(KIND_BYTE, 8'h55, 12'd0);
      send_request(KIND_HEADER, 8'h00, MAX_INSERT_RESET);
      send_request(KIND_POP, 8'h00, 12'hFFF);
      send_request(KIND_POP, 8'h00, 12'd5);
      send_request(KIND_CLEAR, 8'h00, 12'd0);
   endtask

   task automatic full_length_headers();
      send_request(KIND_CLEAR, 8'h00, 12'd0);
      send_insert(4095, 3, 0);
      send_insert(3, 3, 0);
      send_request(KIND_HEADER, 8'h00, 12'hFFF);
   endtask

   task automatic bulk_traffic();
      int i;
      send_request(KIND_CLEAR, 8'h00, 12'd0);
      send_insert(40, 40, 1);
      send_request(KIND_PEEK, 8'h00, CNT_W'(sb.used_count() - 1));
      send_request(KIND_LINE, 8'h00, 12'd64);
      // walk the head through the stored bytes
      for (i = 0; i < 8; i++) begin
         maybe_pause();
         send_request(KIND_PEEK, BYTE_W'($urandom_range(0, 255)),
                      CNT_W'($urandom_range(0, sb.used_count() - 1)));
         send_request(KIND_LINE, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(2, 64)));
         send_request(KIND_POP, BYTE_W'($urandom_range(0, 255)), CNT_W'($urandom_range(1, 4)));
      end
      random_traffic(20);
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      calm = 1'b0;
      pressure_req = 1'b0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_CLEAR;
      req_if.data_byte = '0;
      req_if.count = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_DELIMITER;
      csr_if.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      directed_checks();

      retune(DELIM_RESET, MAX_INSERT_RESET);
      pressure_req = 1'b1;
      random_traffic(100);

      retune(8'h00, 12'd0);
      random_traffic(30);

      retune(8'hFF, 12'hFFF);
      full_length_headers();
      random_traffic(70);

      retune(DELIM_RESET, MAX_INSERT_RESET);
      bulk_traffic();

      retune(CR_BYTE, 12'd7);
      calm = 1'b1;
      random_traffic(50);

      wait_idle();
      $display("Covered %0d requests over %0d register settings, %0d response beats checked.",
               requests_sent, settings_used, sb.checked);
      $display("Line peeks: %0d (%0d ended on a line end); full ring: %0s; index wrap: %0s.",
               sb.line_peeks, sb.lines_found, sb.full_seen ? "yes" : "no",
               sb.wrap_seen ? "yes" : "no");
      if (sb.errors == 0 && sb.due_responses.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
